>>> hdl/dap_request_length_framer_assert.svh
// Assertion macros for the request length framer.
// Included by the top level; depends on clk_i and rst_ni in the including scope.
`ifndef DAP_REQUEST_LENGTH_FRAMER_ASSERT_SVH
`define DAP_REQUEST_LENGTH_FRAMER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define DRLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define DRLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/drlf_pkg.sv
// Shared types, command codes and the fixed length table of the request framer.
// No dependencies.
`default_nettype none

package drlf_pkg;

  localparam int unsigned TGT_W = 19;

  localparam logic [7:0] CMD_SWJ_SEQ   = 8'h12;
  localparam logic [7:0] CMD_OTA_WRITE = 8'h82;
  localparam logic [7:0] CMD_BLOCK     = 8'h06;
  localparam logic [7:0] CMD_TRANSFER  = 8'h05;
  localparam logic [7:0] CMD_SWD_SEQ   = 8'h1D;

  localparam logic [15:0] OTA_PAYLOAD_MAX = 16'd496;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HEADER  = 4'd1,
    PH_COLLECT = 4'd2,
    PH_ENTRY   = 4'd3,
    PH_SKIP    = 4'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_COMPLETE   = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_OVERSIZE   = 2'd2
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  cmd;
    logic [9:0]  pos;
    logic [9:0]  exp_len;
    logic [7:0]  entries;
    logic [7:0]  held;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [9:0]  length;
  } frame_res_t;

  // Length of a fixed command; zero marks a command sized from its header.
  function automatic logic [2:0] fixed_length(input logic [7:0] cmd);
    logic [2:0] len;
    case (cmd)
      8'h00, 8'h02, 8'h13: len = 3'd2;
      8'h01, 8'h09:        len = 3'd3;
      8'h04, 8'h08:        len = 3'd6;
      8'h10:               len = 3'd7;
      8'h11, 8'h81:        len = 3'd5;
      CMD_SWJ_SEQ, CMD_OTA_WRITE, CMD_BLOCK, CMD_TRANSFER, CMD_SWD_SEQ: len = 3'd0;
      default:             len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hdl/drlf_in_if.sv
// Request byte channel: one packet byte per item with a buffer end flag.
// No dependencies.
`default_nettype none

interface drlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

>>> hdl/drlf_out_if.sv
// Frame result channel: status and framed length, one item per packet.
// No dependencies.
`default_nettype none

interface drlf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [9:0] frame_length;

  modport source (output valid, output frame_status, output frame_length, input ready);
  modport sink (input valid, input frame_status, input frame_length, output ready);
endinterface

`default_nettype wire

>>> hdl/dap_request_length_framer.sv
// Top level of the debug-probe request length framer.
// Depends on drlf_pkg, drlf_in_if, drlf_out_if, drlf_step and the assertion macro header.
//
// The framer takes one request byte per item and gives one result per packet:
// the framed length when the request completes, incomplete when the byte
// marked as buffer end arrives first, or oversize as soon as the length passes
// PACKET_BYTES (or an OTA payload passes 496 bytes). After a result the rest of
// the buffer is skipped. A byte is taken every cycle unless the input stalls;
// a byte passes an input register, the parse logic and the result register
// before its result appears. The input side stalls only while both registers are
// full and the result is not taken.
`default_nettype none

`include "dap_request_length_framer_assert.svh"

module dap_request_length_framer import drlf_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  drlf_in_if.sink    req_i,
  drlf_out_if.source res_o
);

  logic         s1_valid_q;
  logic [7:0]   s1_byte_q;
  logic         s1_eob_q;
  parse_state_t state_q;
  parse_state_t state_d;
  frame_res_t   step_res;
  logic         proc;
  logic         out_valid_q;
  logic [1:0]   out_status_q;
  logic [9:0]   out_length_q;

  assign proc        = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || proc;

  drlf_step #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_step (
    .state_i         (state_q),
    .data_byte_i     (s1_byte_q),
    .end_of_buffer_i (s1_eob_q),
    .state_o         (state_d),
    .res_o           (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
      if (proc) begin
        state_q <= state_d;
      end
      if (proc && step_res.valid) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_byte_q <= req_i.data_byte;
      s1_eob_q  <= req_i.end_of_buffer;
    end
    if (proc && step_res.valid) begin
      out_status_q <= step_res.status;
      out_length_q <= step_res.length;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.frame_status = out_status_q;
  assign res_o.frame_length = out_length_q;

  `DRLF_ASSERT(a_len_only_on_complete, !out_valid_q || out_status_q == ST_COMPLETE || out_length_q == 10'd0, "Non-complete result carries a length.")
  `DRLF_ASSERT(a_complete_len_range, !out_valid_q || out_status_q != ST_COMPLETE || (out_length_q != 10'd0 && 32'(out_length_q) <= PACKET_BYTES), "Complete length out of range.")
  `DRLF_ASSERT(a_stall_only_when_full, req_i.ready || (s1_valid_q && out_valid_q), "Input stalled with a free register.")
  `DRLF_ASSERT_NEXT(a_skip_after_result, proc && step_res.valid && !s1_eob_q, state_q.phase == PH_SKIP, "Parser did not skip after a result.")

endmodule

`default_nettype wire

>>> hdl/drlf_step.sv
// Next-state and result logic of the framer for one request byte.
// Depends on drlf_pkg.
`default_nettype none

module drlf_step import drlf_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 512
) (
  input  parse_state_t state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         end_of_buffer_i,
  output parse_state_t state_o,
  output frame_res_t   res_o
);

  always_comb begin
    parse_state_t      nxt;
    frame_res_t        res;
    logic              active;
    logic              tgt_en;
    logic [TGT_W-1:0]  tgt_len;
    logic              seg_en;
    logic [9:0]        pos_inc;
    logic [10:0]       pos_p1;
    logic [10:0]       tgt_p1;
    logic [2:0]        fix_len;
    logic [8:0]        bit_sum;
    logic [5:0]        seq_bytes;
    logic [15:0]       count;
    logic [3:0]        add_len;

    nxt       = state_i;
    res       = '0;
    active    = 1'b1;
    tgt_en    = 1'b0;
    tgt_len   = '0;
    seg_en    = 1'b0;
    pos_inc   = state_i.pos + 10'd1;
    pos_p1    = {1'b0, pos_inc} + 11'd1;
    fix_len   = fixed_length(data_byte_i);
    bit_sum   = {1'b0, data_byte_i} + 9'd7;
    seq_bytes = (data_byte_i == 8'd0) ? 6'd32 : bit_sum[8:3];
    count     = '0;
    add_len   = '0;

    case (state_i.phase)
      PH_IDLE: begin
        nxt.cmd     = data_byte_i;
        nxt.pos     = '0;
        nxt.entries = '0;
        nxt.held    = '0;
        nxt.exp_len = '0;
        if (fix_len == 3'd0) begin
          nxt.phase = PH_HEADER;
        end else begin
          tgt_en  = 1'b1;
          tgt_len = TGT_W'(fix_len);
        end
      end
      PH_HEADER: begin
        nxt.pos = pos_inc;
        case (state_i.cmd)
          CMD_SWJ_SEQ: begin
            if (pos_inc == 10'd1) begin
              tgt_en  = 1'b1;
              tgt_len = TGT_W'(seq_bytes) + TGT_W'(2);
            end
          end
          CMD_OTA_WRITE: begin
            if (pos_inc == 10'd5) begin
              nxt.held = data_byte_i;
            end else if (pos_inc == 10'd6) begin
              count = {data_byte_i, state_i.held};
              if (count > OTA_PAYLOAD_MAX) begin
                res.valid  = 1'b1;
                res.status = ST_OVERSIZE;
              end else begin
                tgt_en  = 1'b1;
                tgt_len = TGT_W'(count) + TGT_W'(7);
              end
            end
          end
          CMD_BLOCK: begin
            if (pos_inc == 10'd2) begin
              nxt.held = data_byte_i;
            end else if (pos_inc == 10'd3) begin
              nxt.entries = data_byte_i;
            end else if (pos_inc == 10'd4) begin
              count       = {state_i.entries, state_i.held};
              nxt.entries = '0;
              tgt_en      = 1'b1;
              tgt_len     = data_byte_i[1] ? TGT_W'(5)
                                           : TGT_W'({count, 2'b00}) + TGT_W'(5);
            end
          end
          CMD_TRANSFER: begin
            if (pos_inc == 10'd2) begin
              nxt.entries = data_byte_i;
              tgt_en      = 1'b1;
              tgt_len     = TGT_W'(3);
            end
          end
          CMD_SWD_SEQ: begin
            if (pos_inc == 10'd1) begin
              nxt.entries = data_byte_i;
              tgt_en      = 1'b1;
              tgt_len     = TGT_W'(2);
            end
          end
          default: begin
          end
        endcase
      end
      PH_COLLECT: begin
        nxt.pos = pos_inc;
        if (pos_p1 >= {1'b0, state_i.exp_len}) begin
          seg_en = 1'b1;
        end
      end
      PH_ENTRY: begin
        nxt.pos     = pos_inc;
        nxt.entries = state_i.entries - 8'd1;
        if (state_i.cmd == CMD_TRANSFER) begin
          if (!data_byte_i[1] || data_byte_i[4]) begin
            add_len = 4'd4;
          end
        end else if (!data_byte_i[7]) begin
          add_len = (data_byte_i[5:0] == 6'd0) ? 4'd8
                                               : 4'(({1'b0, data_byte_i[5:0]} + 7'd7) >> 3);
        end
        tgt_en  = 1'b1;
        tgt_len = TGT_W'(pos_p1) + TGT_W'(add_len);
      end
      default: begin
        active = 1'b0;
      end
    endcase

    tgt_p1 = {1'b0, nxt.pos} + 11'd1;
    if (tgt_en) begin
      if (tgt_len > TGT_W'(PACKET_BYTES)) begin
        res.valid  = 1'b1;
        res.status = ST_OVERSIZE;
      end else begin
        nxt.exp_len = tgt_len[9:0];
        if (tgt_len <= TGT_W'(tgt_p1)) begin
          seg_en = 1'b1;
        end else begin
          nxt.phase = PH_COLLECT;
        end
      end
    end

    if (seg_en) begin
      if (nxt.entries == 8'd0) begin
        res.valid  = 1'b1;
        res.status = ST_COMPLETE;
        res.length = nxt.exp_len;
      end else begin
        nxt.phase = PH_ENTRY;
      end
    end

    if (res.valid) begin
      nxt.phase = end_of_buffer_i ? PH_IDLE : PH_SKIP;
    end else if (end_of_buffer_i) begin
      nxt.phase = PH_IDLE;
      if (active) begin
        res.valid  = 1'b1;
        res.status = ST_INCOMPLETE;
      end
    end

    state_o = nxt;
    res_o   = res;
  end

endmodule

`default_nettype wire
